// ----- src/lisplex_pkg.sv -----
// Shared types, codes and constants of the S-expression lexer.
package lisplex_pkg;

	localparam int POS_W       = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_INT     = 3'd2,
		MODE_DEC     = 3'd3,
		MODE_STR     = 3'd4,
		MODE_SYM     = 3'd5
	} lex_mode_t;

	typedef enum logic [2:0] {
		EV_BYTE   = 3'd0,
		EV_END    = 3'd1,
		EV_LBEGIN = 3'd2,
		EV_LEND   = 3'd3,
		EV_UNTERM = 3'd4,
		EV_BAD    = 3'd5
	} lex_event_t;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_INT  = 3'd1,
		KIND_DEC  = 3'd2,
		KIND_STR  = 3'd3,
		KIND_SYM  = 3'd4
	} lex_kind_t;

	typedef struct packed {
		lex_event_t ev;
		lex_kind_t  kind;
		logic [7:0] ch;
	} lex_res_t;

	// One queue entry: the one or two results of one request.
	typedef struct packed {
		logic        two;
		lex_res_t    res0;
		lex_res_t    res1;
		logic [15:0] line;
		logic [15:0] col;
	} lex_entry_t;

	typedef struct packed {
		logic       valid;
		lex_entry_t entry;
	} lex_slot_t;

	// Clamp a position count to the 16-bit output field.
	function automatic logic [15:0] clamp_pos(input logic [POS_W-1:0] v);
		logic [POS_W+15:0] wide;
		wide = {16'b0, v};
		if (wide > (POS_W+16)'(17'h0FFFF))
			return 16'hFFFF;
		else
			return wide[15:0];
	endfunction

endpackage

// ----- src/lisplex_ifs.sv -----
// Valid/ready channel interfaces for source bytes and lexer results.
interface lisplex_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_text;

	modport source(output valid, output char_byte, output end_of_text, input ready);
	modport sink(input valid, input char_byte, input end_of_text, output ready);
endinterface

interface lisplex_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [2:0]  token_kind;
	logic [7:0]  char_value;
	logic [15:0] line_number;
	logic [15:0] column_number;
	logic        last;

	modport source(output valid, output event_res, output token_kind, output char_value,
		output line_number, output column_number, output last, input ready);
	modport sink(input valid, input event_res, input token_kind, input char_value,
		input line_number, input column_number, input last, output ready);
endinterface

// ----- src/lisplex_front.sv -----
// Front end: accept bytes, track mode and position, build result entries.
module lisplex_front
	import lisplex_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	lisplex_in_if.sink    chars,
	input  logic          full,
	output lex_slot_t     push
);

	lex_mode_t        mode_q, mode_d;
	logic [POS_W-1:0] line_q, line_d;
	logic [POS_W-1:0] col_q, col_d;
	logic             accept;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_graph(input logic [7:0] c);
		return c inside {[8'h21:8'h7E]};
	endfunction

	assign chars.ready = !full;
	assign accept      = chars.valid && !full;

	always_comb begin
		logic [7:0] c;
		logic       fresh;
		logic       s_valid;
		lex_res_t   s_res;
		lex_mode_t  s_mode;
		lex_res_t   r0;
		lex_res_t   r1;
		logic [1:0] n;

		c       = chars.char_byte;
		fresh   = 1'b0;
		s_valid = 1'b0;
		s_res   = '{ev: EV_BYTE, kind: KIND_NONE, ch: 8'h00};
		s_mode  = MODE_IDLE;
		r0      = '{ev: EV_BYTE, kind: KIND_NONE, ch: 8'h00};
		r1      = r0;
		n       = 2'd0;
		mode_d  = mode_q;
		line_d  = line_q;
		col_d   = col_q;

		if (chars.end_of_text) begin
			mode_d = MODE_IDLE;
			case (mode_q)
				MODE_INT: begin
					r0 = '{ev: EV_END, kind: KIND_INT, ch: 8'h00};
					n  = 2'd1;
				end
				MODE_DEC: begin
					r0 = '{ev: EV_END, kind: KIND_DEC, ch: 8'h00};
					n  = 2'd1;
				end
				MODE_SYM: begin
					r0 = '{ev: EV_END, kind: KIND_SYM, ch: 8'h00};
					n  = 2'd1;
				end
				MODE_STR: begin
					r0 = '{ev: EV_UNTERM, kind: KIND_NONE, ch: 8'h00};
					n  = 2'd1;
				end
				default: ;
			endcase
		end else begin
			// Positions follow every real byte, saturating.
			if (c == CH_LF) begin
				if (line_q != {POS_W{1'b1}})
					line_d = line_q + POS_W'(1);
				col_d = '0;
			end else if (col_q != {POS_W{1'b1}}) begin
				col_d = col_q + POS_W'(1);
			end

			case (mode_q)
				MODE_COMMENT: begin
					if (c == CH_LF)
						mode_d = MODE_IDLE;
				end
				MODE_STR: begin
					n = 2'd1;
					if (c == CH_QUOTE) begin
						r0     = '{ev: EV_END, kind: KIND_STR, ch: 8'h00};
						mode_d = MODE_IDLE;
					end else begin
						r0 = '{ev: EV_BYTE, kind: KIND_STR, ch: c};
					end
				end
				MODE_INT: begin
					n = 2'd1;
					if (is_digit(c)) begin
						r0 = '{ev: EV_BYTE, kind: KIND_INT, ch: c};
					end else if (c == CH_DOT) begin
						r0     = '{ev: EV_BYTE, kind: KIND_DEC, ch: c};
						mode_d = MODE_DEC;
					end else begin
						r0    = '{ev: EV_END, kind: KIND_INT, ch: 8'h00};
						fresh = 1'b1;
					end
				end
				MODE_DEC: begin
					n = 2'd1;
					if (is_digit(c)) begin
						r0 = '{ev: EV_BYTE, kind: KIND_DEC, ch: c};
					end else begin
						r0    = '{ev: EV_END, kind: KIND_DEC, ch: 8'h00};
						fresh = 1'b1;
					end
				end
				MODE_SYM: begin
					n = 2'd1;
					if (!is_space(c) && c != CH_LPAR && c != CH_RPAR) begin
						r0 = '{ev: EV_BYTE, kind: KIND_SYM, ch: c};
					end else begin
						r0    = '{ev: EV_END, kind: KIND_SYM, ch: 8'h00};
						fresh = 1'b1;
					end
				end
				default: fresh = 1'b1;
			endcase

			// A byte seen between tokens, or the one that just ended a token.
			if (fresh) begin
				if (is_space(c)) begin
					s_mode = MODE_IDLE;
				end else if (c == CH_HASH) begin
					s_mode = MODE_COMMENT;
				end else if (is_digit(c)) begin
					s_valid = 1'b1;
					s_res   = '{ev: EV_BYTE, kind: KIND_INT, ch: c};
					s_mode  = MODE_INT;
				end else if (c == CH_LPAR) begin
					s_valid = 1'b1;
					s_res   = '{ev: EV_LBEGIN, kind: KIND_NONE, ch: 8'h00};
				end else if (c == CH_RPAR) begin
					s_valid = 1'b1;
					s_res   = '{ev: EV_LEND, kind: KIND_NONE, ch: 8'h00};
				end else if (c == CH_QUOTE) begin
					s_mode = MODE_STR;
				end else if (is_graph(c)) begin
					s_valid = 1'b1;
					s_res   = '{ev: EV_BYTE, kind: KIND_SYM, ch: c};
					s_mode  = MODE_SYM;
				end else begin
					s_valid = 1'b1;
					s_res   = '{ev: EV_BAD, kind: KIND_NONE, ch: 8'h00};
				end
				mode_d = s_mode;
				if (s_valid) begin
					if (n == 2'd0) begin
						r0 = s_res;
						n  = 2'd1;
					end else begin
						r1 = s_res;
						n  = 2'd2;
					end
				end
			end
		end

		push.valid      = accept && (n != 2'd0);
		push.entry.two  = (n == 2'd2);
		push.entry.res0 = r0;
		push.entry.res1 = r1;
		push.entry.line = clamp_pos(line_d);
		push.entry.col  = clamp_pos(col_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= POS_W'(1);
			col_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q  <= col_d;
		end
	end

	// A comment body never yields a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !chars.end_of_text && mode_q == MODE_COMMENT) |-> !push.valid)
		else $error("result pushed from inside a comment");

endmodule

// ----- src/lisplex_queue.sv -----
// Small register FIFO of result entries between front and back end.
module lisplex_queue
	import lisplex_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lex_slot_t  push,
	output logic       full,
	output lex_slot_t  head,
	input  logic       pop
);

	lex_entry_t        entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid)
			entries_q[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (push.valid && !pop)
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (!push.valid && pop)
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push.valid |-> !full)
		else $error("push into full queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head.valid)
		else $error("pop from empty queue");

endmodule

// ----- src/lisplex_back.sv -----
// Back end: drain queue entries one result at a time into the output register.
module lisplex_back
	import lisplex_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  lex_slot_t     head,
	output logic          pop,
	lisplex_out_if.source tokens
);

	lex_res_t    res_q;
	logic [15:0] line_q;
	logic [15:0] col_q;
	logic        last_q;
	logic        valid_q;
	logic        idx_q;
	logic        load;
	logic        last_d;

	assign load   = head.valid && (!valid_q || tokens.ready);
	assign last_d = !head.entry.two || idx_q;
	assign pop    = load && last_d;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= idx_q ? head.entry.res1 : head.entry.res0;
			line_q <= head.entry.line;
			col_q  <= head.entry.col;
			last_q <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && !tokens.ready);
			if (load)
				idx_q <= !last_d;
		end
	end

	assign tokens.valid         = valid_q;
	assign tokens.event_res     = res_q.ev;
	assign tokens.token_kind    = res_q.kind;
	assign tokens.char_value    = res_q.ch;
	assign tokens.line_number   = line_q;
	assign tokens.column_number = col_q;
	assign tokens.last          = last_q;

	// Second result is pending only for a two-result entry still at the head.
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> (head.valid && head.entry.two))
		else $error("second result selected without a two-result entry");

endmodule

// ----- src/lisp_token_lexer.sv -----
// Top level of the S-expression lexer: front end, entry queue and back end.
// Path: a request's results are written into the entry queue, then loaded into the output register.
// Throughput: one request per cycle while each yields at most one result and the queue is not
// full; a request that yields two results occupies the output register for both of them, and the
// four-entry queue between front and back end absorbs such bursts.
// Reset: mode idle, line one, column zero, queue and output register empty.
module lisp_token_lexer
	import lisplex_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	lisplex_in_if.sink    chars,
	lisplex_out_if.source tokens
);

	// Entry built by the front end for each request that yields results.
	lex_slot_t push;
	// Oldest entry waiting in the queue.
	lex_slot_t head;
	logic      full;
	logic      pop;

	// Classify each byte, advance mode and position, hold off when queue is full.
	lisplex_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.full   (full),
		.push   (push)
	);

	// Decouple byte intake from result delivery.
	lisplex_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.head   (head),
		.pop    (pop)
	);

	// Emit one result per cycle while the receiver is ready; drop an entry after its last result.
	lisplex_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the S-expression lexer, with driver, monitor and token predictor.
module testbench
	import lisplex_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_FIRST_GRAPH = 8'h21;
	localparam logic [7:0] CH_LAST_GRAPH  = 8'h7E;

	localparam int RANDOM_PER_PHASE = 260;
	localparam int HOLD_CYCLES      = 64;
	localparam int TAIL_CYCLES      = 16;

	// One source request: a byte or the end-of-text mark.
	typedef struct {
		logic [7:0] ch;
		logic       eot;
	} src_req_t;

	// One expected lexer result.
	typedef struct {
		lex_event_t  ev;
		lex_kind_t   kind;
		logic [7:0]  ch;
		logic [15:0] line;
		logic [15:0] col;
		logic        last;
	} lex_result_t;

	logic clk = 1'b0;
	logic arst_n;

	lisplex_in_if  chars_if();
	lisplex_out_if tokens_if();

	lisp_token_lexer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tokens_if)
	);

	always #6 clk = ~clk;

	// Stimulus and expectation stores.
	src_req_t    src_bytes[$];
	lex_result_t pending_tokens[$];
	src_req_t    drv_req;

	// Predictor state: mirrors the lexer mode and the position counters.
	lex_mode_t        lex_mode = MODE_IDLE;
	logic [POS_W-1:0] line_cnt = 1;
	logic [POS_W-1:0] col_cnt  = 0;

	// Flow control knobs, written by the sequencing block; hold_cnt and hold_done by the result side.
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_req      = 1'b0;
	int   hold_cnt      = 0;
	logic hold_done     = 1'b0;

	logic in_taken = 1'b0;
	int   err_cnt  = 0;
	int   res_idx  = 0;

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_graph(input logic [7:0] c);
		return c >= CH_FIRST_GRAPH && c <= CH_LAST_GRAPH;
	endfunction

	// Clip a position counter to the 16-bit result field.
	function automatic logic [15:0] clip_position(input logic [POS_W-1:0] v);
		longint unsigned w;
		w = v;
		if (w > 64'hFFFF)
			return 16'hFFFF;
		return w[15:0];
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns result %0d: %s: got %0d, expected %0d", $realtime, res_idx, what, got,
			want);
		err_cnt++;
	endtask

	task automatic add_result(input lex_event_t ev, input lex_kind_t kind, input logic [7:0] ch);
		lex_result_t r;
		r.ev   = ev;
		r.kind = kind;
		r.ch   = ch;
		r.line = clip_position(line_cnt);
		r.col  = clip_position(col_cnt);
		r.last = 1'b0;
		pending_tokens.insert(pending_tokens.size(), r);
	endtask

	// Advance the lexer by one accepted request and queue the results it causes.
	task automatic advance_lexer(input logic [7:0] c, input logic eot);
		int   n0;
		logic start_ok;
		n0 = pending_tokens.size();
		start_ok = 1'b0;
		if (eot) begin
			// Flush the open token; comment and idle flush silently.
			case (lex_mode)
				MODE_INT: add_result(EV_END, KIND_INT, 8'h00);
				MODE_DEC: add_result(EV_END, KIND_DEC, 8'h00);
				MODE_SYM: add_result(EV_END, KIND_SYM, 8'h00);
				MODE_STR: add_result(EV_UNTERM, KIND_NONE, 8'h00);
				default: ;
			endcase
			lex_mode = MODE_IDLE;
		end else begin
			// Count every real byte before building results, saturating.
			if (c == CH_LF) begin
				if (line_cnt != {POS_W{1'b1}})
					line_cnt++;
				col_cnt = '0;
			end else if (col_cnt != {POS_W{1'b1}}) begin
				col_cnt++;
			end
			case (lex_mode)
				MODE_COMMENT: begin
					if (c == CH_LF)
						lex_mode = MODE_IDLE;
				end
				MODE_STR: begin
					if (c == CH_QUOTE) begin
						add_result(EV_END, KIND_STR, 8'h00);
						lex_mode = MODE_IDLE;
					end else begin
						add_result(EV_BYTE, KIND_STR, c);
					end
				end
				MODE_INT: begin
					if (is_digit(c)) begin
						add_result(EV_BYTE, KIND_INT, c);
					end else if (c == CH_DOT) begin
						add_result(EV_BYTE, KIND_DEC, c);
						lex_mode = MODE_DEC;
					end else begin
						add_result(EV_END, KIND_INT, 8'h00);
						lex_mode = MODE_IDLE;
						start_ok = 1'b1;
					end
				end
				MODE_DEC: begin
					if (is_digit(c)) begin
						add_result(EV_BYTE, KIND_DEC, c);
					end else begin
						add_result(EV_END, KIND_DEC, 8'h00);
						lex_mode = MODE_IDLE;
						start_ok = 1'b1;
					end
				end
				MODE_SYM: begin
					if (!is_space(c) && c != CH_LPAR && c != CH_RPAR) begin
						add_result(EV_BYTE, KIND_SYM, c);
					end else begin
						add_result(EV_END, KIND_SYM, 8'h00);
						lex_mode = MODE_IDLE;
						start_ok = 1'b1;
					end
				end
				default: begin
					lex_mode = MODE_IDLE;
					start_ok = 1'b1;
				end
			endcase
			// A byte that closed a token, or arrived while idle, may open the next one.
			if (start_ok) begin
				if (is_space(c)) begin
				end else if (c == CH_HASH) begin
					lex_mode = MODE_COMMENT;
				end else if (is_digit(c)) begin
					add_result(EV_BYTE, KIND_INT, c);
					lex_mode = MODE_INT;
				end else if (c == CH_LPAR) begin
					add_result(EV_LBEGIN, KIND_NONE, 8'h00);
				end else if (c == CH_RPAR) begin
					add_result(EV_LEND, KIND_NONE, 8'h00);
				end else if (c == CH_QUOTE) begin
					lex_mode = MODE_STR;
				end else if (is_graph(c)) begin
					add_result(EV_BYTE, KIND_SYM, c);
					lex_mode = MODE_SYM;
				end else begin
					add_result(EV_BAD, KIND_NONE, 8'h00);
				end
			end
		end
		if (pending_tokens.size() > n0)
			pending_tokens[$].last = 1'b1;
	endtask

	// Request builders.
	task automatic push_byte(input logic [7:0] b);
		src_req_t r;
		r.ch  = b;
		r.eot = 1'b0;
		src_bytes.insert(src_bytes.size(), r);
	endtask

	task automatic push_eot();
		src_req_t r;
		// The byte is ignored here, so let it wander.
		r.ch  = 8'($urandom_range(255));
		r.eot = 1'b1;
		src_bytes.insert(src_bytes.size(), r);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] pick_space(input logic allow_lf);
		int k;
		k = $urandom_range(5);
		if (k == 5)
			return CH_SPACE;
		if (!allow_lf && CH_TAB + 8'(k) == CH_LF)
			return CH_CR;
		return CH_TAB + 8'(k);
	endfunction

	function automatic logic [7:0] pick_sym_start();
		logic [7:0] b;
		do
			b = 8'($urandom_range(CH_FIRST_GRAPH, CH_LAST_GRAPH));
		while (is_digit(b) || b == CH_LPAR || b == CH_RPAR || b == CH_QUOTE || b == CH_HASH);
		return b;
	endfunction

	function automatic logic [7:0] pick_sym_body();
		logic [7:0] b;
		do
			b = ($urandom_range(99) < 85) ?
				8'($urandom_range(CH_FIRST_GRAPH, CH_LAST_GRAPH)) : 8'($urandom_range(255));
		while (is_space(b) || b == CH_LPAR || b == CH_RPAR);
		return b;
	endfunction

	function automatic logic [7:0] pick_unprintable();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (is_space(b) || is_graph(b));
		return b;
	endfunction

	// Build mostly well-formed S-expression text with random content, plus some noise.
	task automatic queue_random_text(input int count);
		int added;
		int sel;
		int len;
		logic [7:0] b;
		added = src_bytes.size();
		count = count + added;
		while (src_bytes.size() < count) begin
			sel = $urandom_range(99);
			if (sel < 18) begin
				len = $urandom_range(1, 4);
				repeat (len) push_byte(pick_digit());
				if ($urandom_range(99) < 35) begin
					push_byte(CH_DOT);
					repeat ($urandom_range(3)) push_byte(pick_digit());
					if ($urandom_range(99) < 15)
						push_byte(CH_DOT);
				end
			end else if (sel < 36) begin
				push_byte(pick_sym_start());
				repeat ($urandom_range(5)) push_byte(pick_sym_body());
			end else if (sel < 50) begin
				push_byte(CH_QUOTE);
				len = $urandom_range(6);
				repeat (len) begin
					do
						b = 8'($urandom_range(255));
					while (b == CH_QUOTE);
					push_byte(b);
				end
				if ($urandom_range(99) < 90)
					push_byte(CH_QUOTE);
			end else if (sel < 62) begin
				push_byte($urandom_range(1) ? CH_LPAR : CH_RPAR);
			end else if (sel < 80) begin
				repeat ($urandom_range(1, 2)) push_byte(pick_space(1'b1));
			end else if (sel < 86) begin
				push_byte(CH_HASH);
				repeat ($urandom_range(4)) begin
					do
						b = 8'($urandom_range(255));
					while (b == CH_LF);
					push_byte(b);
				end
				if ($urandom_range(99) < 85)
					push_byte(CH_LF);
			end else if (sel < 90) begin
				push_byte(pick_unprintable());
			end else if (sel < 94) begin
				push_eot();
			end else begin
				repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
			end
		end
	endtask

	// Block until every queued request is taken and every expected result has come back.
	task automatic wait_drained();
		while (src_bytes.size() != 0 || chars_if.valid)
			@(posedge clk);
		while (pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	// Driver: present requests on the falling edge, hold each until it is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			chars_if.valid <= 1'b0;
		end else if (!chars_if.valid || in_taken) begin
			if (src_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_req = src_bytes.pop_front();
				chars_if.valid       <= 1'b1;
				chars_if.char_byte   <= drv_req.ch;
				chars_if.end_of_text <= drv_req.eot;
			end else begin
				chars_if.valid <= 1'b0;
			end
		end
	end

	// Result side flow control: one long hold-off on request, else random stalls.
	always @(negedge clk) begin
		if (!arst_n) begin
			tokens_if.ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			tokens_if.ready <= 1'b0;
			if (hold_cnt == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
			hold_cnt <= hold_cnt + 1;
		end else begin
			tokens_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: check outgoing results first, then predict from the request taken at this edge.
	// A request taken now cannot produce a result at this same edge, so the order is safe.
	always @(posedge clk) begin
		lex_result_t want;
		if (arst_n) begin
			if (tokens_if.valid && tokens_if.ready) begin
				if (pending_tokens.size() == 0) begin
					report_mismatch("unexpected result, event", tokens_if.event_res, -1);
				end else begin
					want = pending_tokens.pop_front();
					if (tokens_if.event_res !== want.ev)
						report_mismatch("event_res", tokens_if.event_res, want.ev);
					if (tokens_if.token_kind !== want.kind)
						report_mismatch("token_kind", tokens_if.token_kind, want.kind);
					if (tokens_if.char_value !== want.ch)
						report_mismatch("char_value", tokens_if.char_value, want.ch);
					if (tokens_if.line_number !== want.line)
						report_mismatch("line_number", tokens_if.line_number, want.line);
					if (tokens_if.column_number !== want.col)
						report_mismatch("column_number", tokens_if.column_number, want.col);
					if (tokens_if.last !== want.last)
						report_mismatch("last", tokens_if.last, want.last);
				end
				res_idx++;
			end
			if (chars_if.valid && chars_if.ready)
				advance_lexer(chars_if.char_byte, chars_if.end_of_text);
		end
		in_taken <= chars_if.valid && chars_if.ready;
	end

	// Sequencing: reset, directed text, then three random phases.
	initial begin
		arst_n               = 1'b0;
		chars_if.valid       = 1'b0;
		chars_if.char_byte   = 8'h00;
		chars_if.end_of_text = 1'b0;
		tokens_if.ready      = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 25;
		recv_idle_pct = 78;

		// Lists, an integer ended by space, a decimal cut by a second dot that opens a symbol,
		// and a symbol closed by a paren.
		push_text("(12 3..x)");
		// String holding the extreme byte values.
		push_byte(CH_QUOTE);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_QUOTE);
		// Unprintable byte between tokens.
		push_byte(8'h7F);
		// Empty comment closed by newline.
		push_byte(CH_HASH);
		push_byte(CH_LF);
		// Quote and hash are plain symbol content; end of text closes the symbol.
		push_text("a\"#");
		push_eot();
		// End of text inside a string, then again while idle.
		push_text("\"q");
		push_eot();
		push_eot();
		wait_drained();

		queue_random_text(RANDOM_PER_PHASE);
		wait_drained();

		send_idle_pct = 78;
		recv_idle_pct = 25;
		queue_random_text(RANDOM_PER_PHASE);
		wait_drained();

		// No idling; the result side first holds off long enough to back up the input.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		queue_random_text(RANDOM_PER_PHASE);
		push_eot();
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_tokens.size() != 0)
			report_mismatch("results never delivered", 0, pending_tokens.size());
		if (err_cnt == 0)
			$display("lisp_token_lexer verification clean");
		else
			$display("lisp_token_lexer verification failed");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#1_000_000;
		$display("lisp_token_lexer verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/lisplex_pkg.sv
src/lisplex_ifs.sv
src/lisplex_front.sv
src/lisplex_queue.sv
src/lisplex_back.sv
src/lisp_token_lexer.sv
verif/testbench.sv
